[rtl/acc_pkg.sv]
// Shared types and constants for the additive checksum compensator.
// No dependencies; imported by additive_checksum_compensator_core.
`timescale 1ns / 1ps

package acc_pkg;

    localparam int POS_W     = 24;   // byte position counter width (wraps)
    localparam int OFF_W     = 24;
    localparam int SIZE_W    = 16;
    localparam int CMP_W     = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0] MIN_AREA = SIZE_W'(4);

    localparam logic [2:0] PATCH_NONE = 3'd0;
    localparam logic [2:0] PATCH_HALF = 3'd2;
    localparam logic [2:0] PATCH_WORD = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 3'd0,
        CFG_SIZE   = 3'd1,
        CFG_TGT8   = 3'd2,
        CFG_TGT16  = 3'd3,
        CFG_TGT32  = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_ALL_KEPT  = 3'd0,
        ST_WIDE_KEPT = 3'd1,
        ST_HALF_ONLY = 3'd2,
        ST_FAILED    = 3'd3,
        ST_TOO_SMALL = 3'd4
    } t_status;

endpackage

[rtl/additive_checksum_compensator_core.sv]
// Additive checksum compensator: running sum8/16/32 over a byte stream and
// a patch word for a zeroed compensation area. Depends on acc_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_data_byte/last  | to block
//  out     | o_out_valid, i_out_stall, sums/patch/stat | from block
//  cfg     | i_cfg_valid, o_cfg_ready, index, data     | to block
//
// One byte beat per cycle while o_in_stall is low. The result of a last byte is
// registered through capture, patch prep and evaluation into the output register.
// Reset (i_rst_n low, synchronous) clears running sums, pipeline valids and
// sets config to offset 0, size 4, targets 0. o_in_stall rises only when the
// result pipeline is full and the output is stalled. Config is always ready.
`timescale 1ns / 1ps

module additive_checksum_compensator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_orig_sum8,
    output logic [15:0]                    o_orig_sum16,
    output logic [31:0]                    o_orig_sum32,
    output logic [31:0]                    o_patch_value,
    output logic [2:0]                     o_patch_bytes,
    output logic [7:0]                     o_new_sum8,
    output logic [15:0]                    o_new_sum16,
    output logic [31:0]                    o_new_sum32,
    output logic [2:0]                     o_status
);
    import acc_pkg::*;

    // configuration
    logic [OFF_W-1:0]  r_off;
    logic [SIZE_W-1:0] r_size;
    logic [7:0]        r_tgt8;
    logic [15:0]       r_tgt16;
    logic [31:0]       r_tgt32;

    // running state
    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_full8, r_mask8, n_full8, n_mask8;
    logic [15:0]       r_full16, r_mask16, n_full16, n_mask16;
    logic [31:0]       r_full32, r_mask32, n_full32, n_mask32;
    logic [23:0]       r_wa_full, r_wa_mask, n_wa_full, n_wa_mask;

    logic [SIZE_W-1:0] area;
    logic [CMP_W-1:0]  area_end;
    logic [CMP_W-1:0]  cur_len;
    logic              in_area;
    logic [7:0]        mb;
    logic [1:0]        lane;
    logic [15:0]       hf, hm;

    // capture stage
    logic              r_f_valid;
    logic [7:0]        r_f_o8, r_f_m8;
    logic [15:0]       r_f_o16, r_f_m16;
    logic [31:0]       r_f_o32, r_f_m32;
    logic [CMP_W-1:0]  r_f_len;

    // patch prep stage
    logic              r_w_valid;
    logic              r_w_small;
    logic [7:0]        r_w_o8, r_w_m8;
    logic [15:0]       r_w_o16, r_w_m16;
    logic [31:0]       r_w_o32, r_w_m32;
    logic [31:0]       r_w_word, r_w_c32w, r_w_c32h;
    logic [15:0]       r_w_half, r_w_hwa, r_w_hwb, r_w_hwh;

    logic [31:0]       n_word, n_c32w, n_c32h;
    logic [15:0]       n_half, n_hwa, n_hwb, n_hwh;
    logic [CMP_W-1:0]  end16, end32;
    logic [CMP_W-1:0]  p_pos [4];
    logic [1:0]        p_lane [4];
    logic [3:0]        inc16, inc32;

    // evaluation / output stage
    logic              r_o_valid;
    logic [7:0]        r_o_o8, r_o_n8;
    logic [15:0]       r_o_o16, r_o_n16;
    logic [31:0]       r_o_o32, r_o_n32, r_o_pv;
    logic [2:0]        r_o_pb;
    t_status           r_o_st;

    logic [7:0]        s8w, s8h;
    logic [15:0]       s16w, s16h;
    logic [31:0]       s32w, s32h;
    logic [7:0]        n_o_n8;
    logic [15:0]       n_o_n16;
    logic [31:0]       n_o_n32, n_o_pv;
    logic [2:0]        n_o_pb;
    t_status           n_o_st;

    logic in_acc, o_free, w_free, f_free, f_adv, w_adv;

    assign o_free     = !r_o_valid || !i_out_stall;
    assign w_free     = !r_w_valid || o_free;
    assign f_free     = !r_f_valid || w_free;
    assign f_adv      = r_f_valid && w_free;
    assign w_adv      = r_w_valid && o_free;
    assign o_in_stall = !f_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------- running sums ----------------
    always_comb begin
        lane     = r_pos[1:0];
        area     = (r_size < MIN_AREA) ? MIN_AREA : r_size;
        area_end = CMP_W'(r_off) + CMP_W'(area);
        in_area  = (CMP_W'(r_pos) >= CMP_W'(r_off)) && (CMP_W'(r_pos) < area_end);
        mb       = in_area ? 8'd0 : i_data_byte;
        cur_len  = CMP_W'(r_pos) + CMP_W'(1);

        n_full8 = r_full8 + i_data_byte;
        n_mask8 = r_mask8 + mb;

        hf = {i_data_byte, (lane[1] ? r_wa_full[23:16] : r_wa_full[7:0])};
        hm = {mb, (lane[1] ? r_wa_mask[23:16] : r_wa_mask[7:0])};
        n_full16 = lane[0] ? r_full16 + hf : r_full16;
        n_mask16 = lane[0] ? r_mask16 + hm : r_mask16;

        n_full32 = r_full32;
        n_mask32 = r_mask32;
        case (lane)
            2'd0: begin
                n_wa_full = {16'd0, i_data_byte};
                n_wa_mask = {16'd0, mb};
            end
            2'd1: begin
                n_wa_full = {8'd0, i_data_byte, r_wa_full[7:0]};
                n_wa_mask = {8'd0, mb, r_wa_mask[7:0]};
            end
            2'd2: begin
                n_wa_full = {i_data_byte, r_wa_full[15:0]};
                n_wa_mask = {mb, r_wa_mask[15:0]};
            end
            default: begin
                n_full32  = r_full32 + {i_data_byte, r_wa_full};
                n_mask32  = r_mask32 + {mb, r_wa_mask};
                n_wa_full = 24'd0;
                n_wa_mask = 24'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_size <= MIN_AREA;
            r_tgt8 <= '0;
            r_tgt16 <= '0;
            r_tgt32 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OFFSET: r_off   <= i_cfg_data[OFF_W-1:0];
                CFG_SIZE:   r_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_TGT8:   r_tgt8  <= i_cfg_data[7:0];
                CFG_TGT16:  r_tgt16 <= i_cfg_data[15:0];
                CFG_TGT32:  r_tgt32 <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_full8   <= '0;
            r_mask8   <= '0;
            r_full16  <= '0;
            r_mask16  <= '0;
            r_full32  <= '0;
            r_mask32  <= '0;
            r_wa_full <= '0;
            r_wa_mask <= '0;
        end else if (in_acc) begin
            if (i_last_byte) begin
                r_pos     <= '0;
                r_full8   <= '0;
                r_mask8   <= '0;
                r_full16  <= '0;
                r_mask16  <= '0;
                r_full32  <= '0;
                r_mask32  <= '0;
                r_wa_full <= '0;
                r_wa_mask <= '0;
            end else begin
                r_pos     <= r_pos + POS_W'(1);
                r_full8   <= n_full8;
                r_mask8   <= n_mask8;
                r_full16  <= n_full16;
                r_mask16  <= n_mask16;
                r_full32  <= n_full32;
                r_mask32  <= n_mask32;
                r_wa_full <= n_wa_full;
                r_wa_mask <= n_wa_mask;
            end
        end
    end

    // ---------------- capture stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_f_valid <= 1'b1;
        end else if (f_adv) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_f_o8  <= n_full8;
            r_f_o16 <= n_full16;
            r_f_o32 <= n_full32;
            r_f_m8  <= n_mask8;
            r_f_m16 <= n_mask16;
            r_f_m32 <= n_mask32;
            r_f_len <= cur_len;
        end
    end

    // ---------------- patch prep ----------------
    always_comb begin
        n_word = r_tgt32 - r_f_m32;
        n_half = r_tgt16 - r_f_m16;
        end16  = {r_f_len[CMP_W-1:1], 1'b0};
        end32  = {r_f_len[CMP_W-1:2], 2'b00};
        n_c32w = '0;
        n_c32h = '0;
        n_hwa  = '0;
        n_hwb  = '0;
        n_hwh  = '0;
        for (int i = 0; i < 4; i++) begin
            p_pos[i]  = CMP_W'(r_off) + CMP_W'(i);
            p_lane[i] = r_off[1:0] + 2'(i);
            inc16[i]  = p_pos[i] < end16;
            inc32[i]  = p_pos[i] < end32;
            if (inc32[i])
                n_c32w = n_c32w | (32'(n_word[8*i +: 8]) << {p_lane[i], 3'b000});
        end
        for (int i = 0; i < 2; i++) begin
            if (inc16[i]) begin
                n_hwa = n_hwa | (16'(n_word[8*i +: 8]) << {p_lane[i][0], 3'b000});
                n_hwh = n_hwh | (16'(n_half[8*i +: 8]) << {p_lane[i][0], 3'b000});
            end
            if (inc16[i+2])
                n_hwb = n_hwb | (16'(n_word[8*(i+2) +: 8]) << {p_lane[i+2][0], 3'b000});
            if (inc32[i])
                n_c32h = n_c32h | (32'(n_half[8*i +: 8]) << {p_lane[i], 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (w_free) begin
            r_w_valid <= f_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_w_small <= area_end > r_f_len;
            r_w_o8    <= r_f_o8;
            r_w_o16   <= r_f_o16;
            r_w_o32   <= r_f_o32;
            r_w_m8    <= r_f_m8;
            r_w_m16   <= r_f_m16;
            r_w_m32   <= r_f_m32;
            r_w_word  <= n_word;
            r_w_half  <= n_half;
            r_w_c32w  <= n_c32w;
            r_w_c32h  <= n_c32h;
            r_w_hwa   <= n_hwa;
            r_w_hwb   <= n_hwb;
            r_w_hwh   <= n_hwh;
        end
    end

    // ---------------- evaluation ----------------
    always_comb begin
        s8w  = r_w_m8 + r_w_word[7:0] + r_w_word[15:8] + r_w_word[23:16]
             + r_w_word[31:24];
        s16w = r_w_m16 + r_w_hwa + r_w_hwb;
        s32w = r_w_m32 + r_w_c32w;
        s8h  = r_w_m8 + r_w_half[7:0] + r_w_half[15:8];
        s16h = r_w_m16 + r_w_hwh;
        s32h = r_w_m32 + r_w_c32h;

        n_o_n8  = r_w_o8;
        n_o_n16 = r_w_o16;
        n_o_n32 = r_w_o32;
        n_o_pv  = '0;
        n_o_pb  = PATCH_NONE;
        if (r_w_small) begin
            n_o_st = ST_TOO_SMALL;
        end else if (s16w == r_tgt16 && s32w == r_tgt32) begin
            n_o_st  = (s8w == r_tgt8) ? ST_ALL_KEPT : ST_WIDE_KEPT;
            n_o_pv  = r_w_word;
            n_o_pb  = PATCH_WORD;
            n_o_n8  = s8w;
            n_o_n16 = s16w;
            n_o_n32 = s32w;
        end else if (s16h == r_tgt16) begin
            n_o_st  = ST_HALF_ONLY;
            n_o_pv  = {16'd0, r_w_half};
            n_o_pb  = PATCH_HALF;
            n_o_n8  = s8h;
            n_o_n16 = s16h;
            n_o_n32 = s32h;
        end else begin
            n_o_st = ST_FAILED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_o8  <= r_w_o8;
            r_o_o16 <= r_w_o16;
            r_o_o32 <= r_w_o32;
            r_o_n8  <= n_o_n8;
            r_o_n16 <= n_o_n16;
            r_o_n32 <= n_o_n32;
            r_o_pv  <= n_o_pv;
            r_o_pb  <= n_o_pb;
            r_o_st  <= n_o_st;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_orig_sum8   = r_o_o8;
    assign o_orig_sum16  = r_o_o16;
    assign o_orig_sum32  = r_o_o32;
    assign o_patch_value = r_o_pv;
    assign o_patch_bytes = r_o_pb;
    assign o_new_sum8    = r_o_n8;
    assign o_new_sum16   = r_o_n16;
    assign o_new_sum32   = r_o_n32;
    assign o_status      = r_o_st;

    // ---------------- assertions ----------------
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_pos == '0 && r_full32 == '0 && r_wa_mask == '0)
        else $error("running state not cleared after last beat");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_f_valid && r_w_valid && r_o_valid && i_out_stall)
        else $error("input stalled while pipeline has room");

    a_no_patch_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_st == ST_FAILED || r_o_st == ST_TOO_SMALL)
        |-> r_o_pb == PATCH_NONE && r_o_n32 == r_o_o32 && r_o_n8 == r_o_o8)
        else $error("patch reported with failing status");

    a_all_kept_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_st == ST_ALL_KEPT
        |-> r_o_n8 == r_tgt8 && r_o_n16 == r_tgt16 && r_o_n32 == r_tgt32)
        else $error("all-kept status with mismatching sums");

endmodule
